// ----- rtl/core/glob_pattern_matcher_core_assert.svh -----
// Assertion macros shared by the glob matcher core RTL.
`ifndef GLOB_PATTERN_MATCHER_CORE_ASSERT_SVH
`define GLOB_PATTERN_MATCHER_CORE_ASSERT_SVH

`ifndef SYNTH
`define GPM_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define GPM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GPM_ASSERT(label, ante, cons, msg)
`define GPM_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/core/gpm_pkg.sv -----
// Types, constants and codes shared by the glob matcher core.
package gpm_pkg;

  localparam int PATTERN_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH       = 2;
  localparam int QPW               = $clog2(QUEUE_DEPTH);

  localparam int MODE_W    = 2;
  localparam int POS_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 8;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_A     = 8'h61;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;

  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TEXT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END  = 2'd2;

  typedef enum logic [1:0] {
    ST_UNDECIDED = 2'd0,
    ST_MATCH     = 2'd1,
    ST_NOMATCH   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_TEXT,
    CMD_END,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [POS_W-1:0]   pos;
    logic [BYTE_W-1:0]  value;
  } cmd_t;

endpackage

// ----- rtl/core/gpm_front.sv -----
// Input side: accept stream words and classify them into commands.
module gpm_front
  import gpm_pkg::*;
#(
  parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [5:0] position, [13:6] byte_value
  input  logic [MODE_W-1:0]    s_axis_tuser,  // [1:0] mode
  output logic                 push_valid_o,
  output cmd_t                 push_cmd_o,
  input  logic                 push_ready_i
);

  logic [POS_W-1:0]  pos;
  logic [BYTE_W-1:0] value;
  logic              pos_ok;

  assign pos    = s_axis_tdata[POS_W-1:0];
  assign value  = s_axis_tdata[POS_W+BYTE_W-1:POS_W];
  assign pos_ok = int'(pos) < PATTERN_DEPTH;

  always_comb begin
    push_cmd_o.pos   = pos;
    push_cmd_o.value = value;
    unique case (s_axis_tuser)
      MODE_LOAD: push_cmd_o.kind = pos_ok ? CMD_LOAD : CMD_NOP;
      MODE_TEXT: push_cmd_o.kind = CMD_TEXT;
      MODE_END:  push_cmd_o.kind = CMD_END;
      default:   push_cmd_o.kind = CMD_NOP;
    endcase
  end

  assign push_valid_o  = s_axis_tvalid;
  assign s_axis_tready = push_ready_i;

endmodule

// ----- rtl/core/gpm_queue.sv -----
// Short command queue between the input side and the executor.
`include "glob_pattern_matcher_core_assert.svh"

module gpm_queue
  import gpm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_cmd_o,
  input  logic pop_ready_i
);

  localparam int QCW = QPW + 1;

  cmd_t           entry_q [QUEUE_DEPTH];
  logic [QPW-1:0] wptr_q, wptr_d;
  logic [QPW-1:0] rptr_q, rptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           push, pop;

  assign push_ready_o = cnt_q != QCW'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = entry_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = push ? wptr_q + QPW'(1) : wptr_q;
    rptr_d = pop ? rptr_q + QPW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

  `GPM_ASSERT(q_cnt_bound, 1'b1, cnt_q <= QCW'(QUEUE_DEPTH), "queue count overflow")
  `GPM_ASSERT_NXT(q_cnt_inc, push && !pop, cnt_q == QCW'($past(cnt_q) + 1'b1), "queue count up")
  `GPM_ASSERT_NXT(q_cnt_dec, pop && !push, cnt_q == QCW'($past(cnt_q) - 1'b1), "queue count down")

endmodule

// ----- rtl/core/gpm_back.sv -----
// Executor: pattern memory, match sequencer and output register.
`include "glob_pattern_matcher_core_assert.svh"

module gpm_back
  import gpm_pkg::*;
#(
  parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_status_o
);

  localparam int AW = $clog2(PATTERN_DEPTH);
  localparam int CW = $clog2(PATTERN_DEPTH + 1);
  localparam int NCLS = 1 << BYTE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_STAR,
    S_HEAD,
    S_CLASS,
    S_RANGE,
    S_END,
    S_END2
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     cur_q, cur_d;
  logic [CW-1:0]     fb_q, fb_d;
  logic              armed_q, armed_d;
  logic [NCLS-1:0]   bitmap_q, bitmap_d;
  logic [BYTE_W-1:0] last_q, last_d;
  status_e           verdict_q, verdict_d;
  logic [BYTE_W-1:0] text_q, text_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic              oob_q, oob_d;

  logic [BYTE_W-1:0] mem [PATTERN_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic [AW-1:0]     raddr, waddr;
  logic              we;
  logic [BYTE_W-1:0] pat;
  logic [NCLS-1:0]   range_mask;
  logic              hit;

  assign pat   = oob_q ? CH_NUL : rdata_q;
  assign waddr = AW'(cmd_i.pos);
  assign raddr = cur_d[AW-1:0];
  assign oob_d = cur_d >= CW'(PATTERN_DEPTH);
  assign hit   = (pat == text_q) || ((pat == CH_CLOSE) && bitmap_q[text_q]);

  always_comb begin
    for (int i = 0; i < NCLS; i++) begin
      range_mask[i] = (BYTE_W'(i) >= last_q) && (BYTE_W'(i) <= pat);
    end
  end

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    fb_d         = fb_q;
    armed_d      = armed_q;
    bitmap_d     = bitmap_q;
    last_d       = last_q;
    verdict_d    = verdict_q;
    text_d       = text_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    cmd_ready_o  = 1'b0;
    we           = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_ready_o = 1'b1;
          unique case (cmd_i.kind)
            CMD_LOAD: begin
              we           = 1'b1;
              out_valid_d  = 1'b1;
              out_status_d = ST_UNDECIDED;
            end
            CMD_TEXT: begin
              if (verdict_q != ST_UNDECIDED) begin
                out_valid_d  = 1'b1;
                out_status_d = verdict_q;
              end else begin
                text_d  = cmd_i.value;
                state_d = S_START;
              end
            end
            CMD_END: state_d = S_END;
            default: begin
              out_valid_d  = 1'b1;
              out_status_d = ST_UNDECIDED;
            end
          endcase
        end
      end
      S_START: begin
        if (pat == CH_NUL) begin
          verdict_d    = ST_NOMATCH;
          out_status_d = ST_NOMATCH;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else if (pat == CH_STAR) begin
          cur_d   = cur_q + CW'(1);
          state_d = S_STAR;
        end else begin
          state_d = S_HEAD;
        end
      end
      S_STAR: begin
        if (pat == CH_NUL) begin
          verdict_d    = ST_MATCH;
          out_status_d = ST_MATCH;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          armed_d = 1'b1;
          fb_d    = cur_q;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        if (pat == CH_OPEN) begin
          bitmap_d = '0;
          cur_d    = cur_q + CW'(1);
          state_d  = S_CLASS;
        end else begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (hit) begin
            cur_d        = cur_q + CW'(1);
            out_status_d = ST_UNDECIDED;
          end else if (armed_q) begin
            cur_d        = fb_q;
            out_status_d = ST_UNDECIDED;
          end else begin
            verdict_d    = ST_NOMATCH;
            out_status_d = ST_NOMATCH;
          end
        end
      end
      S_CLASS: begin
        if (pat == CH_CLOSE) begin
          state_d = S_HEAD;
        end else if (pat == CH_NUL) begin
          verdict_d    = ST_NOMATCH;
          out_status_d = ST_NOMATCH;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else if (pat == CH_DASH) begin
          cur_d   = cur_q + CW'(1);
          state_d = S_RANGE;
        end else begin
          bitmap_d = bitmap_q | (NCLS'(1) << pat);
          last_d   = pat;
          cur_d    = cur_q + CW'(1);
        end
      end
      S_RANGE: begin
        if (pat == CH_CLOSE || pat == CH_NUL) begin
          verdict_d    = ST_NOMATCH;
          out_status_d = ST_NOMATCH;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          bitmap_d = bitmap_q | range_mask;
          cur_d    = cur_q + CW'(1);
          state_d  = S_CLASS;
        end
      end
      S_END, S_END2: begin
        if (state_q == S_END && verdict_q == ST_UNDECIDED && pat == CH_STAR) begin
          cur_d   = cur_q + CW'(1);
          state_d = S_END2;
        end else begin
          if (state_q == S_END && verdict_q != ST_UNDECIDED) begin
            out_status_d = verdict_q;
          end else begin
            out_status_d = (pat == CH_NUL) ? ST_MATCH : ST_NOMATCH;
          end
          out_valid_d = 1'b1;
          cur_d       = '0;
          fb_d        = '0;
          armed_d     = 1'b0;
          bitmap_d    = '0;
          last_d      = CH_A;
          verdict_d   = ST_UNDECIDED;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      fb_q         <= '0;
      armed_q      <= 1'b0;
      bitmap_q     <= '0;
      last_q       <= CH_A;
      verdict_q    <= ST_UNDECIDED;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_UNDECIDED;
      oob_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      fb_q         <= fb_d;
      armed_q      <= armed_d;
      bitmap_q     <= bitmap_d;
      last_q       <= last_d;
      verdict_q    <= verdict_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      oob_q        <= oob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    text_q <= text_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= cmd_i.value;
    end
    if (we && waddr == raddr) begin
      rdata_q <= cmd_i.value;
    end else begin
      rdata_q <= mem[raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;

  `GPM_ASSERT(b_busy_no_out, state_q != S_IDLE, !out_valid_q, "result pending while busy")
  `GPM_ASSERT(b_cur_bound, 1'b1, cur_q <= CW'(PATTERN_DEPTH), "cursor past pattern end")
  `GPM_ASSERT(b_fb_armed, !armed_q, fb_q == '0, "fallback set without wildcard")

endmodule

// ----- rtl/core/glob_pattern_matcher_core.sv -----
// Glob matcher core: one status word out for every word in. A text word steps through a
// leading '*' and through each byte of a bracket class, since the executor reads the pattern
// memory one byte per cycle on its single read port. A two-word queue separates the input
// side from the executor; the next word starts once the previous status is taken.
module glob_pattern_matcher_core
  import gpm_pkg::*;
#(
  parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [5:0] position, [13:6] byte_value
  input  logic [MODE_W-1:0]    s_axis_tuser,   // [1:0] mode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata    // [1:0] status
);

  logic       push_valid, push_ready;
  cmd_t       push_cmd;
  logic       pop_valid, pop_ready;
  cmd_t       pop_cmd;
  logic [1:0] status;

  gpm_front #(
    .PATTERN_DEPTH(PATTERN_DEPTH)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  gpm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_cmd_i  (push_cmd),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_cmd_o   (pop_cmd),
    .pop_ready_i (pop_ready)
  );

  gpm_back #(
    .PATTERN_DEPTH(PATTERN_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_ready_o (pop_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_status_o(status)
  );

  assign m_axis_tdata = {(M_TDATA_W - 2)'(0), status};

endmodule
